>>> rtl/mdfr_pkg.sv
// Shared types and constants for the Modbus distance frame receiver.
`default_nettype none

package mdfr_pkg;

  // Frame check result codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_ADDRESS  = 3'd2,
    ST_FUNCTION = 3'd3,
    ST_COUNT    = 3'd4,
    ST_CRC      = 3'd5,
    ST_RANGE    = 3'd6
  } frame_status_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_GAP     = 2'd0,
    CFG_SILENCE = 2'd1,
    CFG_ADDR    = 2'd2
  } cfg_reg_t;

  // Checker sequencer states
  typedef enum logic [1:0] {
    CK_IDLE = 2'd0,
    CK_WALK = 2'd1,
    CK_DONE = 2'd2
  } ck_state_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    frame_status_t frame_status;
    logic [15:0]   distance_mm;
    logic          distance_valid;
    logic [5:0]    frame_length;
  } out_word_t;

  localparam logic       MODE_BYTE     = 1'b0;
  localparam logic       MODE_TICK     = 1'b1;
  localparam int         CFG_W         = 16;
  localparam logic [7:0] GAP_RESET     = 8'd5;
  localparam logic [15:0] SILENCE_RESET = 16'd1000;
  localparam logic [7:0] ADDR_RESET    = 8'h06;
  localparam logic [15:0] IDLE_MAX     = 16'hFFFF;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'hA001;
  localparam logic [7:0] FUNC_READ     = 8'h03;
  localparam logic [7:0] DATA_BYTES    = 8'h02;
  localparam logic [7:0] RANGE_HIGH    = 8'hFF;
  localparam int         MIN_FRAME     = 7;

endpackage

`default_nettype wire

>>> rtl/mdfr_buffer.sv
// Frame byte store: one write port, one registered read port.
`default_nettype none

module mdfr_buffer #(
  parameter int BUFFER_BYTES = 32,
  parameter int IDX_W        = 5
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_idx,
  input  wire logic [7:0]       wr_data,
  input  wire logic             rd_en,
  input  wire logic [IDX_W-1:0] rd_idx,
  output logic      [7:0]       rd_data
);

  logic [7:0] mem [BUFFER_BYTES];

  // Write a received byte
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  // Registered read: data appears the cycle after rd_en
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_idx];
    end
  end

endmodule

`default_nettype wire

>>> rtl/mdfr_check.sv
// Frame checker: walks the buffer, runs CRC-16, holds distance, drives results.
`default_nettype none

module mdfr_check #(
  parameter int BUFFER_BYTES = 32,
  parameter int IDX_W        = 5,
  parameter int LEN_W        = 6
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [LEN_W-1:0]    start_len,
  input  wire logic [7:0]          device_address,
  output logic                     rd_en,
  output logic      [IDX_W-1:0]    rd_idx,
  input  wire logic [7:0]          rd_data,
  output logic                     busy,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output mdfr_pkg::out_word_t      out_word
);

  mdfr_pkg::ck_state_t     state, state_next;
  mdfr_pkg::frame_status_t status;

  logic [LEN_W-1:0]  len;
  logic [LEN_W-1:0]  len_m1;
  logic [LEN_W-1:0]  len_m2;
  logic [LEN_W+5:0]  len_ext;
  logic              short_frame;
  logic [LEN_W-1:0]  rd_cnt;
  logic              pr_vld;
  logic [LEN_W-1:0]  pr_idx;
  logic [15:0]       crc;
  logic              addr_bad;
  logic              func_bad;
  logic              cnt_bad;
  logic [7:0]        dist_hi;
  logic [7:0]        dist_lo;
  logic [7:0]        rx_lo;
  logic [7:0]        rx_hi;
  logic [15:0]       held_distance, held_distance_next;
  logic              held_valid, held_valid_next;
  logic              load;

  // One byte of CRC-16/Modbus, reflected polynomial
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'd0, data};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ mdfr_pkg::CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  assign len_m1  = len - LEN_W'(1);
  assign len_m2  = len - LEN_W'(2);
  assign len_ext = {6'd0, len};

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      mdfr_pkg::CK_IDLE: begin
        if (start) begin
          state_next = (start_len < LEN_W'(mdfr_pkg::MIN_FRAME)) ?
                       mdfr_pkg::CK_DONE : mdfr_pkg::CK_WALK;
        end
      end
      mdfr_pkg::CK_WALK: begin
        if (pr_vld && pr_idx == len_m1) begin
          state_next = mdfr_pkg::CK_DONE;
        end
      end
      mdfr_pkg::CK_DONE: begin
        if (load) begin
          state_next = mdfr_pkg::CK_IDLE;
        end
      end
      default: state_next = mdfr_pkg::CK_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    rd_en  = 1'b0;
    load   = 1'b0;
    busy   = 1'b1;
    rd_idx = rd_cnt[IDX_W-1:0];
    unique case (state)
      mdfr_pkg::CK_IDLE: busy  = 1'b0;
      mdfr_pkg::CK_WALK: rd_en = (rd_cnt < len);
      mdfr_pkg::CK_DONE: load  = !out_valid || !out_stall;
      default:           busy  = 1'b1;
    endcase
  end

  // Resolve status in check order and the latched distance that follows
  always_comb begin
    held_distance_next = held_distance;
    held_valid_next    = held_valid;
    if (short_frame) begin
      status = mdfr_pkg::ST_SHORT;
    end else if (addr_bad) begin
      status = mdfr_pkg::ST_ADDRESS;
    end else if (func_bad) begin
      status = mdfr_pkg::ST_FUNCTION;
    end else if (cnt_bad) begin
      status = mdfr_pkg::ST_COUNT;
    end else if (crc != {rx_hi, rx_lo}) begin
      status = mdfr_pkg::ST_CRC;
    end else if (dist_hi == mdfr_pkg::RANGE_HIGH) begin
      status          = mdfr_pkg::ST_RANGE;
      held_valid_next = 1'b0;
    end else begin
      status             = mdfr_pkg::ST_OK;
      held_distance_next = {dist_hi, dist_lo};
      held_valid_next    = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= mdfr_pkg::CK_IDLE;
      pr_vld        <= 1'b0;
      out_valid     <= 1'b0;
      held_distance <= 16'd0;
      held_valid    <= 1'b0;
    end else begin
      state  <= state_next;
      pr_vld <= rd_en;
      if (load) begin
        out_valid     <= 1'b1;
        held_distance <= held_distance_next;
        held_valid    <= held_valid_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Walk datapath: issue reads, fold returned bytes into the checks
  always_ff @(posedge clk) begin
    if (state == mdfr_pkg::CK_IDLE && start) begin
      len         <= start_len;
      short_frame <= (start_len < LEN_W'(mdfr_pkg::MIN_FRAME));
      rd_cnt      <= '0;
      crc         <= mdfr_pkg::CRC_INIT;
    end
    if (rd_en) begin
      rd_cnt <= rd_cnt + LEN_W'(1);
      pr_idx <= rd_cnt;
    end
    if (pr_vld) begin
      if (pr_idx == LEN_W'(0)) addr_bad <= (rd_data != device_address);
      if (pr_idx == LEN_W'(1)) func_bad <= (rd_data != mdfr_pkg::FUNC_READ);
      if (pr_idx == LEN_W'(2)) cnt_bad  <= (rd_data != mdfr_pkg::DATA_BYTES);
      if (pr_idx == LEN_W'(3)) dist_hi  <= rd_data;
      if (pr_idx == LEN_W'(4)) dist_lo  <= rd_data;
      if (pr_idx < len_m2)     crc      <= crc_byte(crc, rd_data);
      if (pr_idx == len_m2)    rx_lo    <= rd_data;
      if (pr_idx == len_m1)    rx_hi    <= rd_data;
    end
  end

  // Load the result word
  always_ff @(posedge clk) begin
    if (load) begin
      out_word.frame_status   <= status;
      out_word.distance_mm    <= held_distance_next;
      out_word.distance_valid <= held_valid_next;
      out_word.frame_length   <= len_ext[5:0];
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == mdfr_pkg::CK_IDLE)
    else $error("frame close requested while checker busy");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    state == mdfr_pkg::CK_WALK |-> rd_cnt <= len)
    else $error("read counter ran past frame length");

  a_proc_bound: assert property (@(posedge clk) disable iff (rst)
    pr_vld |-> pr_idx < len)
    else $error("processed byte index outside frame");

  a_ok_latches: assert property (@(posedge clk) disable iff (rst)
    load && status == mdfr_pkg::ST_OK |=> held_valid && out_valid)
    else $error("good frame did not latch a valid distance");

  a_short_skips: assert property (@(posedge clk) disable iff (rst)
    state == mdfr_pkg::CK_DONE && short_frame |-> $past(state) != mdfr_pkg::CK_WALK)
    else $error("short frame walked the buffer");

endmodule

`default_nettype wire

>>> rtl/modbus_distance_frame_receiver.sv
// Top level: config registers, byte intake, idle timing, buffer and checker.
`default_nettype none

// Receives Modbus RTU read responses one UART byte per input word and times
// inter-frame gaps with millisecond tick words. A byte word, or a tick that
// closes no frame, brings no stall of its own. A tick that closes a frame of
// length N starts a walk of the frame buffer through its single read port,
// one byte per cycle, and input stays stalled while the walk runs (frames
// shorter than seven bytes skip the walk), longer if the result word is
// held by out_stall. One result word is produced per closed frame. Byte
// words and ticks that close nothing produce no result. Config writes
// (gap, silence, device address) belong to idle periods.
module modbus_distance_frame_receiver #(
  parameter int BUFFER_BYTES = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire mdfr_pkg::in_word_t              in_word,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output mdfr_pkg::out_word_t                  out_word,
  input  wire logic                            cfg_we,
  input  wire logic [1:0]                      cfg_idx,
  input  wire logic [mdfr_pkg::CFG_W-1:0]      cfg_data
);

  localparam int IDX_W = $clog2(BUFFER_BYTES);
  localparam int LEN_W = $clog2(BUFFER_BYTES + 1);

  logic [7:0]       gap_ticks;
  logic [15:0]      silence_ticks;
  logic [7:0]       device_address;
  logic [LEN_W-1:0] byte_count, byte_count_next;
  logic [15:0]      idle_count, idle_count_next;
  logic [15:0]      idle_inc;
  logic             accept;
  logic             buf_full;
  logic             wr_en;
  logic             ck_start;
  logic             ck_busy;
  logic             rd_en;
  logic [IDX_W-1:0] rd_idx;
  logic [7:0]       rd_data;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gap_ticks      <= mdfr_pkg::GAP_RESET;
      silence_ticks  <= mdfr_pkg::SILENCE_RESET;
      device_address <= mdfr_pkg::ADDR_RESET;
    end else if (cfg_we) begin
      unique case (mdfr_pkg::cfg_reg_t'(cfg_idx))
        mdfr_pkg::CFG_GAP:     gap_ticks      <= cfg_data[7:0];
        mdfr_pkg::CFG_SILENCE: silence_ticks  <= cfg_data[15:0];
        mdfr_pkg::CFG_ADDR:    device_address <= cfg_data[7:0];
        default:               gap_ticks      <= gap_ticks;
      endcase
    end
  end

  assign accept   = in_valid && !in_stall;
  assign in_stall = ck_busy;
  assign buf_full = (byte_count == LEN_W'(BUFFER_BYTES));
  assign idle_inc = (idle_count == mdfr_pkg::IDLE_MAX) ? idle_count : idle_count + 16'd1;
  assign wr_en    = accept && in_word.mode == mdfr_pkg::MODE_BYTE && !buf_full;

  // Advance byte and idle counts; close a frame past the gap, drop it past the silence
  always_comb begin
    byte_count_next = byte_count;
    idle_count_next = idle_count;
    ck_start        = 1'b0;
    if (accept) begin
      if (in_word.mode == mdfr_pkg::MODE_BYTE) begin
        idle_count_next = 16'd0;
        byte_count_next = buf_full ? '0 : byte_count + LEN_W'(1);
      end else if (idle_inc > silence_ticks) begin
        idle_count_next = 16'd0;
        byte_count_next = '0;
      end else begin
        idle_count_next = idle_inc;
        if (byte_count != '0 && idle_inc > {8'd0, gap_ticks}) begin
          ck_start        = 1'b1;
          byte_count_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      idle_count <= 16'd0;
    end else begin
      byte_count <= byte_count_next;
      idle_count <= idle_count_next;
    end
  end

  mdfr_buffer #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .IDX_W        (IDX_W)
  ) u_buffer (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_idx  (byte_count[IDX_W-1:0]),
    .wr_data (in_word.rx_byte),
    .rd_en   (rd_en),
    .rd_idx  (rd_idx),
    .rd_data (rd_data)
  );

  mdfr_check #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .IDX_W        (IDX_W),
    .LEN_W        (LEN_W)
  ) u_check (
    .clk            (clk),
    .rst            (rst),
    .start          (ck_start),
    .start_len      (byte_count),
    .device_address (device_address),
    .rd_en          (rd_en),
    .rd_idx         (rd_idx),
    .rd_data        (rd_data),
    .busy           (ck_busy),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_word       (out_word)
  );

endmodule

`default_nettype wire

>>> tb/modbus_distance_frame_receiver_tb.sv
// Self-checking testbench for the Modbus distance frame receiver.
`timescale 1ns / 1ps

module modbus_distance_frame_receiver_tb;

  localparam int FRAME_BYTES = 32;
  localparam int QUIET_CYCLES = 48;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 2000000;
  localparam logic [1:0] CFG_UNMAPPED = 2'd3;

  typedef logic [7:0] byte_q_t[$];

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  mdfr_pkg::in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  mdfr_pkg::out_word_t out_word;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_idx = mdfr_pkg::CFG_GAP;
  logic [mdfr_pkg::CFG_W-1:0] cfg_data = '0;

  // Predicted receiver state and register copies
  logic [7:0] rx_buf [FRAME_BYTES];
  int unsigned rx_count = 0;
  logic [15:0] idle_ticks = '0;
  logic [15:0] last_mm = '0;
  logic last_ok = 1'b0;
  logic [7:0] gap_cfg = mdfr_pkg::GAP_RESET;
  logic [15:0] silence_cfg = mdfr_pkg::SILENCE_RESET;
  logic [7:0] addr_cfg = mdfr_pkg::ADDR_RESET;

  mdfr_pkg::out_word_t reply_due[$];
  int fails = 0;
  int words_sent = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_asks = 0;
  int hold_taken = 0;
  int hold_left = 0;
  int cycle_count = 0;

  modbus_distance_frame_receiver #(
    .BUFFER_BYTES(FRAME_BYTES)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word(out_word),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Abort a run that hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("modbus_distance_frame_receiver regression: fail");
      $finish;
    end
  end

  // Drive the output stall: a long hold when asked, random otherwise
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_taken != hold_asks) begin
      hold_taken <= hold_asks;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end
  end

  // Compare each accepted result word with the oldest prediction
  always @(negedge clk) begin
    mdfr_pkg::out_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (reply_due.size() == 0) begin
        $error("unexpected result word: frame_status %0d length %0d",
               out_word.frame_status, out_word.frame_length);
        fails++;
      end else begin
        want = reply_due.pop_front();
        if (out_word.frame_status !== want.frame_status) begin
          $error("frame_status: expected %0d, got %0d", want.frame_status,
                 out_word.frame_status);
          fails++;
        end
        if (out_word.distance_mm !== want.distance_mm) begin
          $error("distance_mm: expected %0d, got %0d", want.distance_mm,
                 out_word.distance_mm);
          fails++;
        end
        if (out_word.distance_valid !== want.distance_valid) begin
          $error("distance_valid: expected %0d, got %0d", want.distance_valid,
                 out_word.distance_valid);
          fails++;
        end
        if (out_word.frame_length !== want.frame_length) begin
          $error("frame_length: expected %0d, got %0d", want.frame_length,
                 out_word.frame_length);
          fails++;
        end
      end
    end
  end

  // One step of the reflected CRC-16 used by Modbus RTU
  function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ mdfr_pkg::CRC_POLY) : (c >> 1);
    return c;
  endfunction

  // Advance the predicted receiver by one input word
  function automatic void deframe_step(mdfr_pkg::in_word_t w);
    mdfr_pkg::out_word_t r;
    mdfr_pkg::frame_status_t st;
    logic [15:0] crc;
    int unsigned n;
    if (w.mode == mdfr_pkg::MODE_BYTE) begin
      idle_ticks = '0;
      if (rx_count < FRAME_BYTES) begin
        rx_buf[rx_count] = w.rx_byte;
        rx_count++;
      end else begin
        rx_count = 0;
      end
      return;
    end
    if (idle_ticks != mdfr_pkg::IDLE_MAX) idle_ticks++;
    // long silence drops any partial frame without a result
    if (idle_ticks > silence_cfg) begin
      rx_count = 0;
      idle_ticks = '0;
      return;
    end
    if (rx_count == 0 || idle_ticks <= gap_cfg) return;
    n = rx_count;
    rx_count = 0;
    if (n < mdfr_pkg::MIN_FRAME) st = mdfr_pkg::ST_SHORT;
    else if (rx_buf[0] != addr_cfg) st = mdfr_pkg::ST_ADDRESS;
    else if (rx_buf[1] != mdfr_pkg::FUNC_READ) st = mdfr_pkg::ST_FUNCTION;
    else if (rx_buf[2] != mdfr_pkg::DATA_BYTES) st = mdfr_pkg::ST_COUNT;
    else begin
      crc = mdfr_pkg::CRC_INIT;
      for (int i = 0; i < n - 2; i++) crc = crc_feed(crc, rx_buf[i]);
      if ({rx_buf[n-1], rx_buf[n-2]} != crc) st = mdfr_pkg::ST_CRC;
      else if (rx_buf[3] == mdfr_pkg::RANGE_HIGH) begin
        st = mdfr_pkg::ST_RANGE;
        last_ok = 1'b0;
      end else begin
        st = mdfr_pkg::ST_OK;
        last_mm = {rx_buf[3], rx_buf[4]};
        last_ok = 1'b1;
      end
    end
    r.frame_status = st;
    r.distance_mm = last_mm;
    r.distance_valid = last_ok;
    r.frame_length = n[5:0];
    reply_due.push_back(r);
  endfunction

  // Build a read response: header, data, optional padding, CRC low byte first
  function automatic byte_q_t build_reply(logic [7:0] a, logic [7:0] f, logic [7:0] c,
                                          logic [15:0] mm, int extra, bit bad_crc);
    byte_q_t q;
    logic [15:0] crc;
    q = {a, f, c, mm[15:8], mm[7:0]};
    repeat (extra) q.push_back(8'($urandom));
    crc = mdfr_pkg::CRC_INIT;
    foreach (q[i]) crc = crc_feed(crc, q[i]);
    if (bad_crc) crc ^= 16'(1 << $urandom_range(15));
    q.push_back(crc[7:0]);
    q.push_back(crc[15:8]);
    return q;
  endfunction

  function automatic byte_q_t good_reply(logic [15:0] mm);
    return build_reply(addr_cfg, mdfr_pkg::FUNC_READ, mdfr_pkg::DATA_BYTES, mm, 0, 1'b0);
  endfunction

  // Offer one word, with an optional random gap, and hold it until taken
  task automatic send_word(logic mode, logic [7:0] b);
    mdfr_pkg::in_word_t w;
    logic stalled;
    w.mode = mode;
    w.rx_byte = b;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    words_sent++;
    deframe_step(w);
  endtask

  task automatic send_bytes(byte_q_t q);
    foreach (q[i]) send_word(mdfr_pkg::MODE_BYTE, q[i]);
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_word(mdfr_pkg::MODE_TICK, 8'($urandom));
  endtask

  // Stop offering, wait for every predicted result, then let the block settle
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (reply_due.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [15:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      mdfr_pkg::CFG_GAP: gap_cfg = data[7:0];
      mdfr_pkg::CFG_SILENCE: silence_cfg = data;
      mdfr_pkg::CFG_ADDR: addr_cfg = data[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Default registers: a frame closes only on the tick past the gap
  task automatic test_reset_defaults();
    send_ticks(1);
    send_bytes(good_reply(16'd3000));
    send_ticks(mdfr_pkg::GAP_RESET);
    send_ticks(1);
    send_ticks(1);
  endtask

  // A frame for each status code in check order, then a second CRC error and the longest frame
  task automatic test_status_codes();
    byte_q_t q;
    wait_quiet();
    cfg_write(mdfr_pkg::CFG_GAP, 16'd2);
    cfg_write(mdfr_pkg::CFG_SILENCE, 16'd1000);
    cfg_write(mdfr_pkg::CFG_ADDR, 16'h0006);
    send_bytes(good_reply(16'h1234));
    send_ticks(3);
    q = good_reply(16'h4321);
    void'(q.pop_back());
    send_bytes(q);
    send_ticks(3);
    send_bytes(build_reply(addr_cfg + 8'd1, mdfr_pkg::FUNC_READ, mdfr_pkg::DATA_BYTES,
                           16'h0102, 0, 1'b0));
    send_ticks(3);
    send_bytes(build_reply(addr_cfg, 8'h04, mdfr_pkg::DATA_BYTES, 16'h0102, 0, 1'b0));
    send_ticks(3);
    send_bytes(build_reply(addr_cfg, mdfr_pkg::FUNC_READ, 8'h03, 16'h0102, 0, 1'b0));
    send_ticks(3);
    send_bytes(build_reply(addr_cfg, mdfr_pkg::FUNC_READ, mdfr_pkg::DATA_BYTES,
                           16'h0102, 0, 1'b1));
    send_ticks(3);
    send_bytes(good_reply(16'hFF00));
    send_ticks(3);
    send_bytes(build_reply(addr_cfg, mdfr_pkg::FUNC_READ, mdfr_pkg::DATA_BYTES,
                           16'h0203, 0, 1'b1));
    send_ticks(3);
    // longest frame that fits the buffer
    send_bytes(build_reply(addr_cfg, mdfr_pkg::FUNC_READ, mdfr_pkg::DATA_BYTES,
                           16'h5A5A, 25, 1'b0));
    send_ticks(3);
  endtask

  // A byte into a full buffer is dropped and restarts the frame
  task automatic test_full_buffer();
    byte_q_t q;
    repeat (FRAME_BYTES + 1) q.push_back(8'($urandom));
    send_bytes(q);
    send_bytes(good_reply(16'h0777));
    send_ticks(gap_cfg + 1);
  endtask

  // Silence against gap, and bytes inside the gap
  task automatic test_gap_and_silence();
    wait_quiet();
    cfg_write(mdfr_pkg::CFG_GAP, 16'd5);
    cfg_write(mdfr_pkg::CFG_SILENCE, 16'd3);
    send_bytes(good_reply(16'h0102));
    send_ticks(6);
    wait_quiet();
    cfg_write(mdfr_pkg::CFG_SILENCE, 16'd5);
    send_bytes(good_reply(16'h0103));
    send_ticks(6);
    wait_quiet();
    cfg_write(mdfr_pkg::CFG_SILENCE, 16'd6);
    send_bytes(good_reply(16'h0104));
    send_ticks(6);
    wait_quiet();
    cfg_write(mdfr_pkg::CFG_SILENCE, 16'd0);
    send_bytes(good_reply(16'h0105));
    send_ticks(2);
    wait_quiet();
    cfg_write(mdfr_pkg::CFG_GAP, 16'd0);
    cfg_write(mdfr_pkg::CFG_SILENCE, 16'd1000);
    send_bytes(good_reply(16'h0106));
    send_ticks(1);
    wait_quiet();
    cfg_write(mdfr_pkg::CFG_GAP, 16'd3);
    send_bytes(good_reply(16'h0107));
    send_ticks(3);
    send_bytes(good_reply(16'h0108));
    send_ticks(4);
  endtask

  // Register extremes, ignored upper data bits and the unmapped index
  task automatic test_register_extremes();
    wait_quiet();
    cfg_write(mdfr_pkg::CFG_GAP, {8'($urandom), 8'hFF});
    cfg_write(mdfr_pkg::CFG_SILENCE, 16'hFFFF);
    cfg_write(mdfr_pkg::CFG_ADDR, {8'($urandom), 8'h00});
    send_bytes(good_reply(16'hFEFF));
    send_ticks(255);
    send_ticks(1);
    wait_quiet();
    cfg_write(mdfr_pkg::CFG_GAP, 16'h0000);
    cfg_write(mdfr_pkg::CFG_ADDR, 16'hFFFF);
    send_bytes(good_reply(16'h0000));
    send_ticks(1);
    send_bytes(build_reply(8'h00, mdfr_pkg::FUNC_READ, mdfr_pkg::DATA_BYTES,
                           16'h0001, 0, 1'b0));
    send_ticks(1);
    wait_quiet();
    cfg_write(CFG_UNMAPPED, 16'hFFFF);
    cfg_write(CFG_UNMAPPED, 16'h0000);
    send_bytes(good_reply(16'h8001));
    send_ticks(1);
  endtask

  // A long quiet spell under the widest silence leaves the receiver ready
  task automatic test_long_quiet();
    wait_quiet();
    cfg_write(mdfr_pkg::CFG_GAP, 16'd3);
    cfg_write(mdfr_pkg::CFG_SILENCE, 16'hFFFF);
    send_ticks(200);
    send_bytes(good_reply(16'h2468));
    send_ticks(4);
  endtask

  // Hold the output long enough for the block to stall its input
  task automatic test_backpressure();
    wait_quiet();
    cfg_write(mdfr_pkg::CFG_GAP, 16'd1);
    cfg_write(mdfr_pkg::CFG_SILENCE, 16'd1000);
    @(negedge clk);
    hold_asks++;
    @(posedge clk);
    repeat (6) begin
      send_bytes(good_reply(16'($urandom)));
      send_ticks(2);
    end
    wait_quiet();
  endtask

  // Mostly well-formed responses with random content, plus noise and broken frames
  task automatic random_burst();
    int pick;
    int keep;
    byte_q_t q;
    logic [15:0] mm;
    pick = $urandom_range(99);
    mm = 16'($urandom);
    if ($urandom_range(9) == 0) mm[15:8] = mdfr_pkg::RANGE_HIGH;
    if (pick < 75) begin
      q = build_reply(($urandom_range(19) == 0) ? 8'($urandom) : addr_cfg,
                      ($urandom_range(19) == 0) ? 8'($urandom) : mdfr_pkg::FUNC_READ,
                      ($urandom_range(19) == 0) ? 8'($urandom) : mdfr_pkg::DATA_BYTES,
                      mm, ($urandom_range(7) == 0) ? $urandom_range(1, 25) : 0,
                      $urandom_range(9) == 0);
    end else if (pick < 85) begin
      q = good_reply(mm);
      keep = $urandom_range(1, 6);
      while (q.size() > keep) void'(q.pop_back());
    end else if (pick < 90) begin
      repeat ($urandom_range(FRAME_BYTES + 1, FRAME_BYTES + 8)) q.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 4)) send_word(1'($urandom_range(1)), 8'($urandom));
      return;
    end
    send_bytes(q);
    // close past the gap, or stop short so the next burst runs on
    if ($urandom_range(9) == 0) send_ticks($urandom_range(0, gap_cfg));
    else send_ticks(gap_cfg + 1 + $urandom_range(0, 2));
  endtask

  task automatic test_random_traffic(int send_pct, int recv_pct, int words);
    int target;
    send_idle_pct = send_pct;
    stall_pct = recv_pct;
    for (int k = 0; k < 2; k++) begin
      wait_quiet();
      cfg_write(mdfr_pkg::CFG_GAP, {8'($urandom), 8'($urandom_range(0, 6))});
      cfg_write(mdfr_pkg::CFG_SILENCE, 16'(gap_cfg + $urandom_range(2, 40)));
      cfg_write(mdfr_pkg::CFG_ADDR, 16'($urandom));
      target = words_sent + words;
      while (words_sent < target) random_burst();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 7;
    stall_pct = 48;
    test_reset_defaults();
    test_status_codes();
    test_full_buffer();
    test_gap_and_silence();
    test_register_extremes();
    test_long_quiet();
    test_backpressure();
    test_random_traffic(7, 48, 150);
    test_random_traffic(48, 7, 150);
    test_random_traffic(0, 0, 150);
    wait_quiet();
    if (fails == 0 && reply_due.size() == 0) begin
      $display("modbus_distance_frame_receiver regression: pass");
    end else begin
      $display("modbus_distance_frame_receiver regression: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/mdfr_pkg.sv
rtl/mdfr_buffer.sv
rtl/mdfr_check.sv
rtl/modbus_distance_frame_receiver.sv
tb/modbus_distance_frame_receiver_tb.sv
